// ----- design/clpu_pkg.sv -----
`default_nettype none
package clpu_pkg;

   localparam int MAX_KEPT_CHARS_DEF   = 30;
   localparam int FRAC_DIGITS_KEPT_DEF = 9;

   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_PX    = 3'd1;
   localparam logic [2:0] KIND_DP    = 3'd2;
   localparam logic [2:0] KIND_PT    = 3'd3;
   localparam logic [2:0] KIND_SCALE = 3'd4;

   localparam int DIV_W = 80;   // mantissa (64) shifted up by 16 fraction bits

   localparam logic [63:0] DEC_GROW_LIMIT = 64'd100000000000000000;
   localparam logic [63:0] DEC_SAT_VALUE  = 64'd1000000000000000000;
   localparam logic [DIV_W-1:0] SAT_QUO   = DIV_W'(64'd3276800) << 16;

   // divide by 100 through reciprocals: ceil(2^29/100) for a 22-bit dividend,
   // ceil(2^30/100) for a 23-bit dividend; both exact over their range
   localparam logic [22:0] PCT_RECIP_HI = 23'd5368710;
   localparam logic [23:0] PCT_RECIP_LO = 24'd10737419;

   // one decided string, handed from the parser to the result stage
   typedef struct packed {
      logic        accepted;
      logic [2:0]  kind;
      logic [31:0] int_value;
      logic        int_converted;
      logic        use_scale;
      logic        dec_neg;
      logic [4:0]  frac_digits;
      logic [63:0] mantissa;
   } clpu_job_type;

   function automatic logic [63:0] pow10(input logic [4:0] n);
      logic [63:0] p;
      case (n)
         5'd0:    p = 64'd1;
         5'd1:    p = 64'd10;
         5'd2:    p = 64'd100;
         5'd3:    p = 64'd1000;
         5'd4:    p = 64'd10000;
         5'd5:    p = 64'd100000;
         5'd6:    p = 64'd1000000;
         5'd7:    p = 64'd10000000;
         5'd8:    p = 64'd100000000;
         5'd9:    p = 64'd1000000000;
         5'd10:   p = 64'd10000000000;
         5'd11:   p = 64'd100000000000;
         5'd12:   p = 64'd1000000000000;
         5'd13:   p = 64'd10000000000000;
         5'd14:   p = 64'd100000000000000;
         5'd15:   p = 64'd1000000000000000;
         5'd16:   p = 64'd10000000000000000;
         5'd17:   p = 64'd100000000000000000;
         default: p = 64'd1000000000000000000;
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

// ----- design/clpu_front.sv -----
`default_nettype none
module clpu_front
   import clpu_pkg::*;
#(
   parameter int MAX_KEPT_CHARS   = MAX_KEPT_CHARS_DEF,
   parameter int FRAC_DIGITS_KEPT = FRAC_DIGITS_KEPT_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire logic [7:0]   ch,
   input  wire logic         start_req,
   output      logic         push,
   output      clpu_job_type job
);

   localparam int KW = $clog2(MAX_KEPT_CHARS + 1);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_NUM   = 2'd1;
   localparam logic [1:0] PH_UNIT2 = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   logic [1:0]    phase_ff, phase_in;
   logic          seen_sign_ff, seen_sign_in, seen_point_ff, seen_point_in;
   logic [KW-1:0] kept_ff, kept_in;
   logic [31:0]   int_acc_ff, int_acc_in;
   logic          int_neg_ff, int_neg_in, int_dig_ff, int_dig_in, int_stop_ff, int_stop_in;
   logic [63:0]   dec_mant_ff, dec_mant_in;
   logic [4:0]    dec_frac_ff, dec_frac_in;
   logic          dec_neg_ff, dec_neg_in, dec_dig_ff, dec_dig_in, dec_stop_ff, dec_stop_in;
   logic          unit_d_ff, unit_d_in;

   logic          is_dig, is_sign, numeric, first;
   logic [3:0]    digit;
   logic [35:0]   t_int, lim;
   logic          emit, use_int;

   always_comb begin
      phase_in      = phase_ff;
      seen_sign_in  = seen_sign_ff;
      seen_point_in = seen_point_ff;
      kept_in       = kept_ff;
      int_acc_in    = int_acc_ff;
      int_neg_in    = int_neg_ff;
      int_dig_in    = int_dig_ff;
      int_stop_in   = int_stop_ff;
      dec_mant_in   = dec_mant_ff;
      dec_frac_in   = dec_frac_ff;
      dec_neg_in    = dec_neg_ff;
      dec_dig_in    = dec_dig_ff;
      dec_stop_in   = dec_stop_ff;
      unit_d_in     = unit_d_ff;
      emit          = 1'b0;
      use_int       = 1'b0;
      job           = '0;

      if (start_req) begin
         phase_in      = PH_NUM;
         seen_sign_in  = 1'b0;
         seen_point_in = 1'b0;
         kept_in       = '0;
         int_acc_in    = '0;
         int_neg_in    = 1'b0;
         int_dig_in    = 1'b0;
         int_stop_in   = 1'b0;
         dec_mant_in   = '0;
         dec_frac_in   = '0;
         dec_neg_in    = 1'b0;
         dec_dig_in    = 1'b0;
         dec_stop_in   = 1'b0;
         unit_d_in     = 1'b0;
      end

      is_dig  = (ch >= "0") && (ch <= "9");
      is_sign = (ch == "+") || (ch == "-");
      digit   = 4'(ch - "0");
      numeric = is_dig || (is_sign && !seen_sign_in) || ((ch == ".") && !seen_point_in);
      first   = (kept_in == '0);
      t_int   = ({4'b0, int_acc_in} << 3) + ({4'b0, int_acc_in} << 1) + 36'(digit);
      lim     = int_neg_in ? 36'h080000000 : 36'h07FFFFFFF;

      case (phase_in)
         PH_NUM: begin
            if (numeric) begin
               if (is_sign) seen_sign_in = 1'b1;
               if (kept_in < KW'(MAX_KEPT_CHARS)) begin
                  // integer reading
                  if (!int_stop_in) begin
                     if (first && is_sign) begin
                        if (ch == "-") int_neg_in = 1'b1;
                     end else if (is_dig) begin
                        int_dig_in = 1'b1;
                        int_acc_in = (t_int > lim) ? lim[31:0] : t_int[31:0];
                     end else begin
                        int_stop_in = 1'b1;
                     end
                  end
                  // decimal reading
                  if (!dec_stop_in) begin
                     if (first && is_sign) begin
                        if (ch == "-") dec_neg_in = 1'b1;
                     end else if (is_dig) begin
                        dec_dig_in = 1'b1;
                        if (!seen_point_in) begin
                           dec_mant_in = (dec_mant_in < DEC_GROW_LIMIT) ?
                              (dec_mant_in << 3) + (dec_mant_in << 1) + 64'(digit) :
                              DEC_SAT_VALUE;
                        end else if ((dec_frac_in < 5'(FRAC_DIGITS_KEPT)) &&
                                     (dec_mant_in < DEC_GROW_LIMIT)) begin
                           dec_mant_in = (dec_mant_in << 3) + (dec_mant_in << 1) +
                                         64'(digit);
                           dec_frac_in = dec_frac_in + 5'd1;
                        end
                     end else if (ch != ".") begin
                        dec_stop_in = 1'b1;
                     end
                  end
                  kept_in = kept_in + KW'(1);
               end
               if (ch == ".") seen_point_in = 1'b1;
            end else if (kept_in == '0) begin
               emit = 1'b1;
            end else if ((ch == "d") || (ch == "D") || (ch == "p") || (ch == "P")) begin
               unit_d_in = (ch == "d") || (ch == "D");
               phase_in  = PH_UNIT2;
            end else if (ch == "%") begin
               emit = 1'b1;
               if (dec_dig_in) begin
                  job.accepted  = 1'b1;
                  job.kind      = KIND_SCALE;
                  job.use_scale = 1'b1;
               end
            end else begin
               emit = 1'b1;
               if ((ch == 8'd0) && int_dig_in) begin
                  job.accepted = 1'b1;
                  job.kind     = KIND_PX;
                  use_int      = 1'b1;
               end
            end
         end
         PH_UNIT2: begin
            emit         = 1'b1;
            job.accepted = 1'b1;
            if (unit_d_in) begin
               if ((ch == "p") || (ch == "P")) begin
                  job.kind = KIND_DP;
                  use_int  = 1'b1;
               end
            end else if ((ch == "x") || (ch == "X")) begin
               job.kind = KIND_PX;
               use_int  = 1'b1;
            end else if ((ch == "t") || (ch == "T")) begin
               job.kind = KIND_PT;
               use_int  = 1'b1;
            end
         end
         default: ;
      endcase

      if (emit) phase_in = PH_DONE;
      if (use_int && int_dig_in) begin
         job.int_converted = 1'b1;
         job.int_value     = int_neg_in ? (32'd0 - int_acc_in) : int_acc_in;
      end
      job.dec_neg     = dec_neg_in;
      job.frac_digits = dec_frac_in;
      job.mantissa    = dec_mant_in;
      push            = fire && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         seen_sign_ff  <= 1'b0;
         seen_point_ff <= 1'b0;
         kept_ff       <= '0;
         int_acc_ff    <= '0;
         int_neg_ff    <= 1'b0;
         int_dig_ff    <= 1'b0;
         int_stop_ff   <= 1'b0;
         dec_mant_ff   <= '0;
         dec_frac_ff   <= '0;
         dec_neg_ff    <= 1'b0;
         dec_dig_ff    <= 1'b0;
         dec_stop_ff   <= 1'b0;
         unit_d_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         seen_sign_ff  <= seen_sign_in;
         seen_point_ff <= seen_point_in;
         kept_ff       <= kept_in;
         int_acc_ff    <= int_acc_in;
         int_neg_ff    <= int_neg_in;
         int_dig_ff    <= int_dig_in;
         int_stop_ff   <= int_stop_in;
         dec_mant_ff   <= dec_mant_in;
         dec_frac_ff   <= dec_frac_in;
         dec_neg_ff    <= dec_neg_in;
         dec_dig_ff    <= dec_dig_in;
         dec_stop_ff   <= dec_stop_in;
         unit_d_ff     <= unit_d_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/clpu_queue.sv -----
`default_nettype none
module clpu_queue
   import clpu_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire clpu_job_type push_job,
   output      logic         full,
   input  wire logic         pop,
   output      logic         head_valid,
   output      clpu_job_type head_job
);

   clpu_job_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop) else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");

endmodule
`default_nettype wire

// ----- design/clpu_back.sv -----
`default_nettype none
module clpu_back
   import clpu_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         head_valid,
   input  wire clpu_job_type head_job,
   output      logic         pop,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [71:0]  rsp_tdata,   // accepted, int_value, int_converted, scale_q16
   output      logic [2:0]   rsp_tuser    // kind
);

   localparam logic [2:0] BK_IDLE = 3'd0;
   localparam logic [2:0] BK_DIV  = 3'd1;
   localparam logic [2:0] BK_PCT1 = 3'd2;
   localparam logic [2:0] BK_PCT2 = 3'd3;
   localparam logic [2:0] BK_PCT3 = 3'd4;
   localparam logic [2:0] BK_DONE = 3'd5;
   localparam int CW = $clog2(DIV_W + 1);

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [63:0]      rem_ff, rem_in, div_ff, div_in;
   logic [DIV_W-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic             neg_ff, neg_in;
   logic [31:0]      mag_ff, mag_in;
   logic [15:0]      pct_hi_ff, pct_hi_in;
   logic [22:0]      pct_lo_ff, pct_lo_in;
   logic             out_valid_ff, out_valid_in;
   logic [71:0]      out_data_ff, out_data_in;
   logic [2:0]       out_kind_ff, out_kind_in;

   logic [64:0]      r2, diff;
   logic             ge, can_load;
   logic [DIV_W-1:0] quo_next;
   logic [31:0]      scale_val;
   logic [21:0]      pct_whole, pct_rem;
   logic [44:0]      pct_prod_hi;
   logic [46:0]      pct_prod_lo;

   assign can_load   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;

   always_comb begin
      r2        = {rem_ff, dvd_ff[DIV_W-1]};
      diff      = r2 - {1'b0, div_ff};
      ge        = (r2 >= {1'b0, div_ff});
      quo_next  = {quo_ff[DIV_W-2:0], ge};
      scale_val = neg_ff ? (32'd0 - mag_ff) :
                  (mag_ff[31] ? 32'h7FFF_FFFF : mag_ff);

      // Q16 value = whole * 2^16 + frac; whole = 100 * hi + rem
      pct_whole   = quo_ff[37:16];
      pct_prod_hi = 45'(pct_whole) * 45'(PCT_RECIP_HI);
      pct_rem     = pct_whole - 22'(pct_hi_ff) * 22'd100;
      pct_prod_lo = 47'(pct_lo_ff) * 47'(PCT_RECIP_LO);

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      pct_hi_in    = pct_hi_ff;
      pct_lo_in    = pct_lo_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_kind_in  = out_kind_ff;
      pop          = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               if (head_job.use_scale) begin
                  pop      = 1'b1;
                  neg_in   = head_job.dec_neg;
                  rem_in   = '0;
                  quo_in   = '0;
                  dvd_in   = {head_job.mantissa, 16'd0};
                  div_in   = pow10(head_job.frac_digits);
                  cnt_in   = CW'(DIV_W);
                  state_in = BK_DIV;
               end else if (can_load) begin
                  pop          = 1'b1;
                  out_valid_in = 1'b1;
                  out_kind_in  = head_job.kind;
                  out_data_in  = {6'd0, 32'd0, head_job.int_converted,
                                  head_job.int_value, head_job.accepted};
               end
            end
         end
         BK_DIV: begin
            rem_in = ge ? diff[63:0] : r2[63:0];
            dvd_in = dvd_ff << 1;
            quo_in = quo_next;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               if (quo_next >= SAT_QUO) begin
                  mag_in   = 32'h8000_0000;
                  state_in = BK_DONE;
               end else begin
                  state_in = BK_PCT1;
               end
            end
         end
         BK_PCT1: begin
            pct_hi_in = pct_prod_hi[44:29];
            state_in  = BK_PCT2;
         end
         BK_PCT2: begin
            pct_lo_in = {pct_rem[6:0], quo_ff[15:0]};
            state_in  = BK_PCT3;
         end
         BK_PCT3: begin
            mag_in   = {pct_hi_ff, pct_prod_lo[45:30]};
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_SCALE;
               out_data_in  = {6'd0, scale_val, 1'b0, 32'd0, 1'b1};
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      pct_hi_ff   <= pct_hi_in;
      pct_lo_ff   <= pct_lo_in;
      out_data_ff <= out_data_in;
      out_kind_ff <= out_kind_in;
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == BK_IDLE)) else $error("pop while divider busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DIV_W)) else $error("divider count out of range");
   a_div_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV && cnt_ff != CW'(1)) |=>
      (state_ff == BK_DIV)) else $error("divider left early");

endmodule
`default_nettype wire

// ----- design/css_length_unit_parser_core.sv -----
// CSS length/unit parser.
// req_ channel: one character per transaction in req_tdata[7:0]; req_tuser
// marks the first character of a new string and aborts any string in flight.
// rsp_ channel: at most one result transaction per string, issued on the
// character that decides it (NUL, %, unit letters or a bad character);
// characters after the decision are dropped until the next start.
// Throughput: one character per cycle while the two-entry job queue between
// parser and result stage has room.
// px/dp/pt/none/reject results reach rsp_ through the job queue and the
// result register. Percent results run the restoring divider, one quotient
// bit per cycle, for mantissa / 10^frac, then reciprocal multiplication for
// the divide by 100 unless the quotient saturates; the queue keeps taking
// characters meanwhile until it fills.
// Reset (synchronous, active high) returns the parser to idle waiting for a
// start, empties the queue and drops any pending result.
// When the receiver holds rsp_tready low the result register holds, the
// queue fills, then req_tready drops.
`default_nettype none
module css_length_unit_parser_core
   import clpu_pkg::*;
#(
   parameter int MAX_KEPT_CHARS   = MAX_KEPT_CHARS_DEF,
   parameter int FRAC_DIGITS_KEPT = FRAC_DIGITS_KEPT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // ch
   input  wire logic        req_tuser,   // start_req
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [71:0] rsp_tdata,   // accepted, int_value, int_converted, scale_q16
   output      logic [2:0]  rsp_tuser    // kind
);

   logic         q_full, push, pop, head_valid, fire;
   clpu_job_type push_job, head_job;

   assign req_tready = !q_full;
   assign fire       = req_tvalid && req_tready;

   clpu_front #(
      .MAX_KEPT_CHARS  (MAX_KEPT_CHARS),
      .FRAC_DIGITS_KEPT(FRAC_DIGITS_KEPT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .ch       (req_tdata),
      .start_req(req_tuser),
      .push     (push),
      .job      (push_job)
   );

   clpu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_job  (head_job)
   );

   clpu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
`default_nettype wire
